// ===== design/bllpg_pkg.sv =====
package bllpg_pkg;

  // Kind of input item, carried on in_tuser
  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_t;

  // Status that travels with a computed pixel
  typedef struct packed {
    logic valid;
    logic last;
  } pix_ctl_t;

  localparam int unsigned COLOR_IN_W = 12;
  localparam int unsigned COLOR_W    = 8;

  localparam logic [2:0] RED3_MASK  = 3'b111;
  localparam logic [1:0] BLUE2_MASK = 2'b11;

  // RGB444 -> RGB332: top 3 bits of red and green, top 2 bits of blue
  function automatic logic [COLOR_W-1:0] to_rgb332(input logic [COLOR_IN_W-1:0] c);
    logic [2:0] r3;
    logic [2:0] g3;
    logic [1:0] b2;
    r3 = c[11:9] & RED3_MASK;
    g3 = c[7:5] & RED3_MASK;
    b2 = c[3:2] & BLUE2_MASK;
    return {r3, g3, b2};
  endfunction

endpackage

// ===== design/bresenham_line_pixel_generator.sv =====
// Bresenham line rasterizer, at most one pixel per input transfer.
//
// Input stream (in_*): in_tuser is the action, ACT_START loads both
// endpoints and the 12-bit RGB444 color and yields the first endpoint;
// ACT_STEP yields the next pixel along the major axis. A step with no
// line in progress yields nothing. A start during a line abandons it.
// Output stream (out_*): one pixel with RGB332 color; out_tlast marks
// the second endpoint, after which the line is done.
//
// Each input transfer passes through the input register, then the
// error/coordinate update into the output register, to its pixel on
// out_*. Throughput: one item per cycle unless out_* stalls, set by
// the single add-compare update of the error term; in_tready stays
// high while the output register is empty or being drained.
//
// Reset (rst_n low, synchronous) empties both registers and clears the
// line state. When the receiver stalls, the pixel holds on out_* and one
// more item waits in the input register before in_tready drops.
module bresenham_line_pixel_generator
  import bllpg_pkg::*;
#(
  parameter int unsigned COORD_BITS = 8
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  // start_x, start_y, end_x, end_y, color_in, zero fill
  input  logic [((4*COORD_BITS+COLOR_IN_W+7)/8)*8-1:0] in_tdata,
  // action
  input  logic                                      in_tuser,
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  // pixel_x, pixel_y, pixel_color, zero fill
  output logic [((2*COORD_BITS+COLOR_W+7)/8)*8-1:0]    out_tdata,
  // last
  output logic                                      out_tlast
);

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned OUT_W = ((2*COORD_BITS+COLOR_W+7)/8)*8;

  // input register -> core
  logic            s1_valid, s1_act, adv, out_free;
  logic [CB-1:0]   s1_sx, s1_sy, s1_ex, s1_ey;
  logic [COLOR_IN_W-1:0] s1_color;

  // core -> output register
  logic [CB-1:0]      res_x, res_y;
  logic [COLOR_W-1:0] res_color;
  pix_ctl_t           res_ctl;

  logic [CB-1:0]      pix_x, pix_y;
  logic [COLOR_W-1:0] pix_color;

  // the held item is processed whenever the output register can load
  assign adv = s1_valid && out_free;

  bllpg_in_stage #(.COORD_BITS(COORD_BITS)) u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_act    (in_tuser),
    .in_sx     (in_tdata[CB-1:0]),
    .in_sy     (in_tdata[2*CB-1:CB]),
    .in_ex     (in_tdata[3*CB-1:2*CB]),
    .in_ey     (in_tdata[4*CB-1:3*CB]),
    .in_color  (in_tdata[4*CB+COLOR_IN_W-1:4*CB]),
    .adv       (adv),
    .valid     (s1_valid),
    .act       (s1_act),
    .sx        (s1_sx),
    .sy        (s1_sy),
    .ex        (s1_ex),
    .ey        (s1_ey),
    .color     (s1_color)
  );

  bllpg_core #(.COORD_BITS(COORD_BITS)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (adv),
    .act       (s1_act),
    .sx        (s1_sx),
    .sy        (s1_sy),
    .ex        (s1_ex),
    .ey        (s1_ey),
    .color     (s1_color),
    .res_x     (res_x),
    .res_y     (res_y),
    .res_color (res_color),
    .res_ctl   (res_ctl)
  );

  bllpg_out_stage #(.COORD_BITS(COORD_BITS)) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (adv),
    .res_x      (res_x),
    .res_y      (res_y),
    .res_color  (res_color),
    .res_ctl    (res_ctl),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .pix_x      (pix_x),
    .pix_y      (pix_y),
    .pix_color  (pix_color),
    .pix_last   (out_tlast)
  );

  // zero fill up to whole bytes
  assign out_tdata = OUT_W'({pix_color, pix_y, pix_x});

endmodule

// ===== design/bllpg_in_stage.sv =====
module bllpg_in_stage
  import bllpg_pkg::*;
#(
  parameter int unsigned COORD_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  in_act,
  input  logic [COORD_BITS-1:0] in_sx,
  input  logic [COORD_BITS-1:0] in_sy,
  input  logic [COORD_BITS-1:0] in_ex,
  input  logic [COORD_BITS-1:0] in_ey,
  input  logic [COLOR_IN_W-1:0] in_color,
  input  logic                  adv,      // held item moves on this cycle
  output logic                  valid,
  output logic                  act,
  output logic [COORD_BITS-1:0] sx,
  output logic [COORD_BITS-1:0] sy,
  output logic [COORD_BITS-1:0] ex,
  output logic [COORD_BITS-1:0] ey,
  output logic [COLOR_IN_W-1:0] color
);

  logic                  valid_r, valid_nxt;
  logic                  act_r;
  logic [COORD_BITS-1:0] sx_r, sy_r, ex_r, ey_r;
  logic [COLOR_IN_W-1:0] color_r;
  logic                  load;

  assign in_tready = !valid_r || adv;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      act_r   <= in_act;
      sx_r    <= in_sx;
      sy_r    <= in_sy;
      ex_r    <= in_ex;
      ey_r    <= in_ey;
      color_r <= in_color;
    end
  end

  assign valid = valid_r;
  assign act   = act_r;
  assign sx    = sx_r;
  assign sy    = sy_r;
  assign ex    = ex_r;
  assign ey    = ey_r;
  assign color = color_r;

endmodule

// ===== design/bllpg_core.sv =====
module bllpg_core
  import bllpg_pkg::*;
#(
  parameter int unsigned COORD_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,     // item consumed this cycle
  input  logic                  act,
  input  logic [COORD_BITS-1:0] sx,
  input  logic [COORD_BITS-1:0] sy,
  input  logic [COORD_BITS-1:0] ex,
  input  logic [COORD_BITS-1:0] ey,
  input  logic [COLOR_IN_W-1:0] color,
  output logic [COORD_BITS-1:0] res_x,
  output logic [COORD_BITS-1:0] res_y,
  output logic [COLOR_W-1:0]    res_color,
  output pix_ctl_t              res_ctl
);

  localparam int unsigned DBL_W = COORD_BITS + 2;
  localparam int unsigned ERR_W = COORD_BITS + 3;

  function automatic logic [COORD_BITS-1:0] step_c(input logic [COORD_BITS-1:0] v,
                                                   input logic neg);
    return neg ? (v - COORD_BITS'(1)) : (v + COORD_BITS'(1));
  endfunction

  // line state
  logic                  busy_r, busy_nxt;
  logic [COORD_BITS-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [COORD_BITS-1:0] goal_x_r, goal_x_nxt, goal_y_r, goal_y_nxt;
  logic [ERR_W-1:0]      err_r, err_nxt;       // two's complement
  logic [DBL_W-1:0]      tdx_r, tdx_nxt, tdy_r, tdy_nxt;
  logic                  dxn_r, dxn_nxt, dyn_r, dyn_nxt;
  logic                  xmaj_r, xmaj_nxt;
  logic [COLOR_W-1:0]    lcol_r, lcol_nxt;

  // start setup
  logic signed [COORD_BITS:0] dx_s, dy_s;
  logic [COORD_BITS-1:0]      adx, ady;
  logic                       st_xmaj;

  // step
  logic             minor_go;
  logic [ERR_W-1:0] tdx_e, tdy_e;

  assign dx_s    = $signed({1'b0, ex}) - $signed({1'b0, sx});
  assign dy_s    = $signed({1'b0, ey}) - $signed({1'b0, sy});
  assign adx     = dx_s[COORD_BITS] ? COORD_BITS'(-dx_s) : dx_s[COORD_BITS-1:0];
  assign ady     = dy_s[COORD_BITS] ? COORD_BITS'(-dy_s) : dy_s[COORD_BITS-1:0];
  assign st_xmaj = adx > ady;

  assign tdx_e    = ERR_W'(tdx_r);
  assign tdy_e    = ERR_W'(tdy_r);
  assign minor_go = !err_r[ERR_W-1];

  always_comb begin
    busy_nxt   = busy_r;
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    goal_x_nxt = goal_x_r;
    goal_y_nxt = goal_y_r;
    err_nxt    = err_r;
    tdx_nxt    = tdx_r;
    tdy_nxt    = tdy_r;
    dxn_nxt    = dxn_r;
    dyn_nxt    = dyn_r;
    xmaj_nxt   = xmaj_r;
    lcol_nxt   = lcol_r;
    res_ctl    = '{valid: 1'b0, last: 1'b0};

    unique case (action_t'(act))
      ACT_START: begin
        dxn_nxt    = dx_s[COORD_BITS];
        dyn_nxt    = dy_s[COORD_BITS];
        tdx_nxt    = DBL_W'({adx, 1'b0});
        tdy_nxt    = DBL_W'({ady, 1'b0});
        xmaj_nxt   = st_xmaj;
        err_nxt    = st_xmaj ? (ERR_W'({ady, 1'b0}) - ERR_W'(adx))
                             : (ERR_W'({adx, 1'b0}) - ERR_W'(ady));
        lcol_nxt   = to_rgb332(color);
        cur_x_nxt  = sx;
        cur_y_nxt  = sy;
        goal_x_nxt = ex;
        goal_y_nxt = ey;
        busy_nxt   = st_xmaj ? (sx != ex) : (sy != ey);
        res_ctl    = '{valid: 1'b1, last: !busy_nxt};
      end
      ACT_STEP: begin
        if (busy_r) begin
          if (xmaj_r) begin
            if (minor_go) begin
              cur_y_nxt = step_c(cur_y_r, dyn_r);
            end
            cur_x_nxt = step_c(cur_x_r, dxn_r);
            err_nxt   = err_r - (minor_go ? tdx_e : '0) + tdy_e;
            busy_nxt  = cur_x_nxt != goal_x_r;
          end else begin
            if (minor_go) begin
              cur_x_nxt = step_c(cur_x_r, dxn_r);
            end
            cur_y_nxt = step_c(cur_y_r, dyn_r);
            err_nxt   = err_r - (minor_go ? tdy_e : '0) + tdx_e;
            busy_nxt  = cur_y_nxt != goal_y_r;
          end
          res_ctl = '{valid: 1'b1, last: !busy_nxt};
        end
      end
      default: ;
    endcase
  end

  assign res_x     = cur_x_nxt;
  assign res_y     = cur_y_nxt;
  assign res_color = lcol_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      goal_x_r <= '0;
      goal_y_r <= '0;
      err_r    <= '0;
      tdx_r    <= '0;
      tdy_r    <= '0;
      dxn_r    <= 1'b0;
      dyn_r    <= 1'b0;
      xmaj_r   <= 1'b0;
      lcol_r   <= '0;
    end else if (take) begin
      busy_r   <= busy_nxt;
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      goal_x_r <= goal_x_nxt;
      goal_y_r <= goal_y_nxt;
      err_r    <= err_nxt;
      tdx_r    <= tdx_nxt;
      tdy_r    <= tdy_nxt;
      dxn_r    <= dxn_nxt;
      dyn_r    <= dyn_nxt;
      xmaj_r   <= xmaj_nxt;
      lcol_r   <= lcol_nxt;
    end
  end

endmodule

// ===== design/bllpg_out_stage.sv =====
module bllpg_out_stage
  import bllpg_pkg::*;
#(
  parameter int unsigned COORD_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,      // core consumes an item this cycle
  input  logic [COORD_BITS-1:0] res_x,
  input  logic [COORD_BITS-1:0] res_y,
  input  logic [COLOR_W-1:0]    res_color,
  input  pix_ctl_t              res_ctl,
  output logic                  free,      // register can load this cycle
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [COORD_BITS-1:0] pix_x,
  output logic [COORD_BITS-1:0] pix_y,
  output logic [COLOR_W-1:0]    pix_color,
  output logic                  pix_last
);

  logic                  valid_r, valid_nxt;
  logic [COORD_BITS-1:0] x_r, y_r;
  logic [COLOR_W-1:0]    col_r;
  logic                  last_r;

  assign free      = !valid_r || out_tready;
  assign valid_nxt = free ? (take && res_ctl.valid) : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (free && take && res_ctl.valid) begin
      x_r    <= res_x;
      y_r    <= res_y;
      col_r  <= res_color;
      last_r <= res_ctl.last;
    end
  end

  assign out_tvalid = valid_r;
  assign pix_x      = x_r;
  assign pix_y      = y_r;
  assign pix_color  = col_r;
  assign pix_last   = last_r;

endmodule

// ===== design/bllpg_checker.sv =====
module bllpg_checker
  import bllpg_pkg::*;
#(
  parameter int unsigned COORD_BITS = 8
) (
  input logic                                       clk,
  input logic                                       rst_n,
  input logic                                       in_tvalid,
  input logic                                       in_tready,
  input logic                                       in_tuser,
  input logic                                       out_tvalid,
  input logic                                       out_tready,
  input logic [((2*COORD_BITS+COLOR_W+7)/8)*8-1:0]     out_tdata,
  input logic                                       out_tlast
);

  // a start transfer always yields a pixel on the output
  a_start_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == ACT_START)) |-> ##2 out_tvalid)
    else $error("start transfer produced no pixel");

  // input never blocks while the output register is empty
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("out_tvalid dropped during stall");

  a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> ($stable(out_tdata) && $stable(out_tlast)))
    else $error("output payload changed during stall");

endmodule

bind bresenham_line_pixel_generator bllpg_checker #(.COORD_BITS(COORD_BITS)) u_bllpg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
